// ===== hw/rtl/fcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// fcsg_pkg
// Shared types, constants and helpers of the filled circle span generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package fcsg_pkg;

  localparam int CENTER_W       = 12;
  localparam int RADIUS_W       = 6;
  localparam int SPAN_W         = 14;
  localparam int OFFSET_W       = 8;
  localparam int DECISION_W     = 11;
  localparam int RESULT_CAP     = 64;
  localparam int COUNT_W        = $clog2(RESULT_CAP);
  localparam int QUEUE_DEPTH    = 2;
  localparam int DEF_MAX_RADIUS = 63;
  localparam int DEF_COORD_BITS = 12;

  typedef struct packed {
    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [RADIUS_W-1:0] radius;
  } req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  typedef enum logic {
    WS_IDLE,
    WS_WALK
  } walk_state_t;

  function automatic logic [CENTER_W-1:0] center_mask(input int bits);
    logic [CENTER_W-1:0] m;
    for (int i = 0; i < CENTER_W; i++) begin
      m[i] = (i < bits);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fcsg_front.sv =====
// ----------------------------------------------------------------------------
// fcsg_front
// Request intake: registers one request, clamps the radius and trims the
// center to the coordinate width, then hands it to the request queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcsg_front import fcsg_pkg::*; #(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic [CENTER_W-1:0] center_x,
  input  wire logic [CENTER_W-1:0] center_y,
  input  wire logic [RADIUS_W-1:0] radius,
  input  wire queue_status_t       q_status,
  output logic                     push,
  output req_t                     push_req
);

  localparam logic [CENTER_W-1:0] CMASK   = center_mask(COORD_BITS);
  localparam logic [RADIUS_W-1:0] RAD_MAX = RADIUS_W'(MAX_RADIUS);

  logic f_valid;
  logic f_valid_next;
  req_t f_req;
  logic accept;

  assign req_stall = f_valid && q_status.full;
  assign accept    = req_valid && !req_stall;
  assign push      = f_valid && !q_status.full;
  assign push_req  = f_req;

  always_comb begin
    f_valid_next = f_valid;
    if (accept) begin
      f_valid_next = 1'b1;
    end else if (push) begin
      f_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else begin
      f_valid <= f_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_req.center_x <= center_x & CMASK;
      f_req.center_y <= center_y & CMASK;
      f_req.radius   <= (radius > RAD_MAX) ? RAD_MAX : radius;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcsg_queue.sv =====
// ----------------------------------------------------------------------------
// fcsg_queue
// Short request queue between intake and the circle walker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcsg_queue import fcsg_pkg::*; (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire req_t          push_req,
  input  wire logic          pop,
  output req_t               pop_req,
  output queue_status_t      q_status
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

  req_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             do_push;
  logic             do_pop;

  assign q_status.empty = (count == '0);
  assign q_status.full  = (count == FULL_CNT);
  assign do_push        = push && !q_status.full;
  assign do_pop         = pop && !q_status.empty;
  assign pop_req        = slots[rd_ptr];

  always_comb begin
    count_next = count;
    if (do_push && !do_pop) begin
      count_next = count + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_next = count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      count <= count_next;
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/fcsg_walker.sv =====
// ----------------------------------------------------------------------------
// fcsg_walker
// Circle walk engine: one walk step per cycle while the output register is
// free, four spans per step, results held in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcsg_walker import fcsg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire queue_status_t     q_status,
  input  wire req_t              pop_req,
  output logic                   pop,
  output logic                   span_valid,
  input  wire logic              span_stall,
  output logic [SPAN_W-1:0]      wide_left_x,
  output logic [SPAN_W-1:0]      wide_right_x,
  output logic [SPAN_W-1:0]      wide_lower_row,
  output logic [SPAN_W-1:0]      wide_upper_row,
  output logic [SPAN_W-1:0]      narrow_left_x,
  output logic [SPAN_W-1:0]      narrow_right_x,
  output logic [SPAN_W-1:0]      narrow_lower_row,
  output logic [SPAN_W-1:0]      narrow_upper_row,
  output logic                   last_step
);

  localparam logic [COUNT_W-1:0] LAST_CNT = COUNT_W'(RESULT_CAP - 1);

  walk_state_t state;
  walk_state_t state_next;

  logic [CENTER_W-1:0]          cx;
  logic [CENTER_W-1:0]          cy;
  logic [RADIUS_W-1:0]          rad;
  logic signed [OFFSET_W-1:0]   ox;
  logic signed [OFFSET_W-1:0]   oy;
  logic signed [DECISION_W-1:0] d;
  logic [COUNT_W-1:0]           n;

  logic signed [OFFSET_W-1:0]   ox_next;
  logic signed [OFFSET_W-1:0]   oy_next;
  logic signed [DECISION_W-1:0] d_next;
  logic signed [DECISION_W-1:0] two_ox;
  logic signed [DECISION_W-1:0] two_oy;
  logic signed [DECISION_W-1:0] two_rm;
  logic                         step_last;
  logic                         advance;
  logic                         out_ready;

  logic signed [SPAN_W-1:0] cx_e;
  logic signed [SPAN_W-1:0] cy_e;
  logic signed [SPAN_W-1:0] ox_e;
  logic signed [SPAN_W-1:0] oy_e;

  assign out_ready = !span_valid || !span_stall;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      WS_IDLE: begin
        if (!q_status.empty) begin
          state_next = WS_WALK;
        end
      end
      WS_WALK: begin
        if (advance && step_last) begin
          state_next = WS_IDLE;
        end
      end
      default: state_next = WS_IDLE;
    endcase
  end

  // outputs of the controller
  always_comb begin
    pop     = 1'b0;
    advance = 1'b0;
    case (state)
      WS_IDLE: pop     = !q_status.empty;
      WS_WALK: advance = out_ready;
      default: begin
        pop     = 1'b0;
        advance = 1'b0;
      end
    endcase
  end

  // one walk step
  always_comb begin
    two_ox = DECISION_W'(ox) <<< 1;
    two_oy = DECISION_W'(oy) <<< 1;
    two_rm = (DECISION_W'($signed({1'b0, rad})) - DECISION_W'(oy)) <<< 1;
    ox_next = ox;
    oy_next = oy;
    if (d >= two_ox) begin
      d_next  = d - two_ox - DECISION_W'(1);
      ox_next = ox + OFFSET_W'(1);
    end else if (d < two_rm) begin
      d_next  = d + two_oy - DECISION_W'(1);
      oy_next = oy - OFFSET_W'(1);
    end else begin
      d_next  = d + two_oy - two_ox - DECISION_W'(2);
      oy_next = oy - OFFSET_W'(1);
      ox_next = ox + OFFSET_W'(1);
    end
    step_last = (oy_next < ox_next) || (n == LAST_CNT);
  end

  assign cx_e = $signed({{(SPAN_W-CENTER_W){1'b0}}, cx});
  assign cy_e = $signed({{(SPAN_W-CENTER_W){1'b0}}, cy});
  assign ox_e = SPAN_W'(ox);
  assign oy_e = SPAN_W'(oy);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= WS_IDLE;
      span_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (advance) begin
        span_valid <= 1'b1;
      end else if (!span_stall) begin
        span_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cx  <= pop_req.center_x;
      cy  <= pop_req.center_y;
      rad <= pop_req.radius;
      ox  <= '0;
      oy  <= OFFSET_W'(pop_req.radius);
      d   <= DECISION_W'(pop_req.radius) - DECISION_W'(1);
      n   <= '0;
    end else if (advance) begin
      ox <= ox_next;
      oy <= oy_next;
      d  <= d_next;
      n  <= n + COUNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      wide_left_x      <= SPAN_W'(cx_e - oy_e);
      wide_right_x     <= SPAN_W'(cx_e + oy_e);
      wide_lower_row   <= SPAN_W'(cy_e + ox_e);
      wide_upper_row   <= SPAN_W'(cy_e - ox_e);
      narrow_left_x    <= SPAN_W'(cx_e - ox_e);
      narrow_right_x   <= SPAN_W'(cx_e + ox_e);
      narrow_lower_row <= SPAN_W'(cy_e + oy_e);
      narrow_upper_row <= SPAN_W'(cy_e - oy_e);
      last_step        <= step_last;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/filled_circle_span_generator.sv =====
// ----------------------------------------------------------------------------
// filled_circle_span_generator
// Turns circle requests into horizontal spans that fill the circle.
//
// Request channel (req_valid / req_stall): one beat carries center_x,
// center_y and radius. Span channel (span_valid / span_stall): one beat
// carries two wide and two narrow spans of one walk step; last_step marks
// the final beat of a circle. A circle of radius r gives one beat per walk
// step, at most r + 1 beats and never more than 64.
// A request passes the intake register and the request queue before the
// walker loads it. Throughput: the walker produces one span beat per cycle
// while the output beat is not stalled, and loads each request in its idle
// state before walking it, one circle at a time. A two-entry request queue lets
// new requests be taken while a circle is still being walked.
// Radii above MAX_RADIUS are clamped; centers keep their low COORD_BITS bits.
// Reset (rst, synchronous) empties the queue and drops any pending beat.
// When span_stall is high a pending span beat is held unchanged and the walk
// pauses; requests keep filling the queue until it is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module filled_circle_span_generator import fcsg_pkg::*; #(
  parameter int MAX_RADIUS = DEF_MAX_RADIUS,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_stall,
  input  wire logic [CENTER_W-1:0] center_x,
  input  wire logic [CENTER_W-1:0] center_y,
  input  wire logic [RADIUS_W-1:0] radius,
  output logic                     span_valid,
  input  wire logic                span_stall,
  output logic [SPAN_W-1:0]        wide_left_x,
  output logic [SPAN_W-1:0]        wide_right_x,
  output logic [SPAN_W-1:0]        wide_lower_row,
  output logic [SPAN_W-1:0]        wide_upper_row,
  output logic [SPAN_W-1:0]        narrow_left_x,
  output logic [SPAN_W-1:0]        narrow_right_x,
  output logic [SPAN_W-1:0]        narrow_lower_row,
  output logic [SPAN_W-1:0]        narrow_upper_row,
  output logic                     last_step
);

  queue_status_t q_status;
  logic          push;
  req_t          push_req;
  logic          pop;
  req_t          pop_req;

  fcsg_front #(
    .MAX_RADIUS(MAX_RADIUS),
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .q_status (q_status),
    .push     (push),
    .push_req (push_req)
  );

  fcsg_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_req(push_req),
    .pop     (pop),
    .pop_req (pop_req),
    .q_status(q_status)
  );

  fcsg_walker u_walker (
    .clk             (clk),
    .rst             (rst),
    .q_status        (q_status),
    .pop_req         (pop_req),
    .pop             (pop),
    .span_valid      (span_valid),
    .span_stall      (span_stall),
    .wide_left_x     (wide_left_x),
    .wide_right_x    (wide_right_x),
    .wide_lower_row  (wide_lower_row),
    .wide_upper_row  (wide_upper_row),
    .narrow_left_x   (narrow_left_x),
    .narrow_right_x  (narrow_right_x),
    .narrow_lower_row(narrow_lower_row),
    .narrow_upper_row(narrow_upper_row),
    .last_step       (last_step)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/fcsg_checker.sv =====
// ----------------------------------------------------------------------------
// fcsg_checker
// Port-level checks of the filled circle span generator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module fcsg_checker import fcsg_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              req_valid,
  input wire logic              req_stall,
  input wire logic [CENTER_W-1:0] center_x,
  input wire logic [CENTER_W-1:0] center_y,
  input wire logic [RADIUS_W-1:0] radius,
  input wire logic              span_valid,
  input wire logic              span_stall,
  input wire logic [SPAN_W-1:0] wide_left_x,
  input wire logic [SPAN_W-1:0] wide_right_x,
  input wire logic [SPAN_W-1:0] wide_lower_row,
  input wire logic [SPAN_W-1:0] wide_upper_row,
  input wire logic [SPAN_W-1:0] narrow_left_x,
  input wire logic [SPAN_W-1:0] narrow_right_x,
  input wire logic [SPAN_W-1:0] narrow_lower_row,
  input wire logic [SPAN_W-1:0] narrow_upper_row,
  input wire logic              last_step
);

  // no span beat right after reset
  a_reset_clears: assert property (@(posedge clk) rst |=> !span_valid)
    else $error("span beat present after reset");

  // stalled span beat stays valid and holds wide_left_x, narrow_upper_row and last_step
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    span_valid && span_stall |=> span_valid && $stable(wide_left_x)
      && $stable(narrow_upper_row) && $stable(last_step))
    else $error("stalled span beat changed");

  // all four spans of a beat share one center column
  a_same_column: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> SPAN_W'(wide_left_x + wide_right_x)
      == SPAN_W'(narrow_left_x + narrow_right_x))
    else $error("span columns disagree");

  // all four spans of a beat share one center row
  a_same_row: assert property (@(posedge clk) disable iff (rst)
    span_valid |-> SPAN_W'(wide_lower_row + wide_upper_row)
      == SPAN_W'(narrow_lower_row + narrow_upper_row))
    else $error("span rows disagree");

  // beats of one circle come without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    span_valid && !span_stall && !last_step |=> span_valid)
    else $error("gap inside a circle");

endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (.*);

`default_nettype wire
